>>> src/trq_pkg.sv
// Shared types and constants for the timestamp reorder queue.
// No dependencies; used by every module of the block.
package trq_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int BATCH = 32;
	localparam logic [5:0] CAP_LIMIT_RST = 6'd32;

	localparam logic [2:0] CMD_QUEUE = 3'd0;
	localparam logic [2:0] CMD_FLUSH_ALL = 3'd1;
	localparam logic [2:0] CMD_FLUSH_HALF = 3'd2;
	localparam logic [2:0] CMD_FLUSH_COUNT = 3'd3;
	localparam logic [2:0] CMD_FLUSH_TIME = 3'd4;
	localparam logic [2:0] CMD_FLUSH_ROUND = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NO_ROOM = 2'd2;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic [2:0] command;
		logic [63:0] timestamp;
		logic [31:0] payload;
		logic [15:0] instance_req;
		logic [63:0] flush_arg;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [63:0] out_timestamp;
		logic [31:0] out_payload;
		logic [15:0] out_instance;
		logic [1:0] status;
		logic [31:0] unordered_total;
		logic [5:0] held_count;
		logic last_of_run;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic bound;
		logic count;
		logic plan;
		logic emit_event;
		logic emit_done;
		logic insert;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rem_zero;
		logic do_insert;
		logic out_free;
	} dp_stat_t;

endpackage

>>> src/trq_ctrl.sv
// Sequencing state machine of the timestamp reorder queue.
// Depends on trq_pkg for the command and status structs.
module trq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output trq_pkg::dp_cmd_t cmd,
	input trq_pkg::dp_stat_t stat
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BOUND = 3'd1;
	localparam logic [2:0] S_COUNT = 3'd2;
	localparam logic [2:0] S_PLAN = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_INSERT = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q, state_nx;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_BOUND;
				end
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_nx = S_COUNT;
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				state_nx = S_PLAN;
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_nx = S_DRAIN;
			end
			S_DRAIN: begin
				if (stat.rem_zero) begin
					state_nx = stat.do_insert ? S_INSERT : S_DONE;
				end else if (stat.out_free) begin
					cmd.emit_event = 1'b1;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_nx = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit_done = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

>>> src/trq_dpath.sv
// Datapath: sorted cell chain, bookkeeping registers and output register.
// Depends on trq_pkg; driven by trq_ctrl through dp_cmd_t.
module trq_dpath #(
	parameter int CAPACITY = trq_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input trq_pkg::in_item_t in_data,
	input logic cfg_wr_en,
	input logic [5:0] cfg_wr_data,
	input logic out_stall,
	output logic out_valid,
	output trq_pkg::out_item_t out_data,
	input trq_pkg::dp_cmd_t cmd,
	output trq_pkg::dp_stat_t stat
);

	localparam int HW = $clog2(CAPACITY + 1);

	// cell chain, sorted oldest first; cells at or above held are unused
	logic [63:0] time_q [CAPACITY];
	logic [31:0] handle_q [CAPACITY];
	logic [15:0] source_q [CAPACITY];

	logic [HW-1:0] held_q, held_after_q, rem_q, pop_q;
	logic [63:0] newest_q, last_flushed_q, round_bound_q, bound_q;
	logic [31:0] late_q;
	logic [5:0] cap_q;
	logic [2:0] op_q;
	logic [63:0] ts_q, arg_q;
	logic [31:0] pl_q;
	logic [15:0] inst_q;
	logic ins_q;
	logic [1:0] status_q;
	logic out_valid_q;
	trq_pkg::out_item_t out_q;

	logic [HW-1:0] lim;
	logic stamp_ok;
	logic [CAPACITY-1:0] gt;
	logic [CAPACITY-1:0] le;
	logic [HW-1:0] pop_c;
	logic [63:0] span, bound_c;
	logic [HW-1:0] d_c, h1_c;

	assign lim = ({1'b0, cap_q} > 7'(CAPACITY)) ? HW'(CAPACITY) : HW'(cap_q);
	assign stamp_ok = (ts_q != '0) && (ts_q != '1);

	always_comb begin
		span = (newest_q >= time_q[0]) ? (newest_q - time_q[0]) : '0;
		case (op_q)
			trq_pkg::CMD_FLUSH_HALF: bound_c = time_q[0] + (span >> 1);
			trq_pkg::CMD_FLUSH_TIME: bound_c = arg_q;
			trq_pkg::CMD_FLUSH_ROUND: bound_c = round_bound_q;
			default: bound_c = '1;
		endcase
	end

	// cells within the bound form a prefix of the chain; its end gives the count
	always_comb begin
		pop_c = '0;
		for (int i = 0; i < CAPACITY; i++)
			le[i] = (HW'(i) < held_q) && (time_q[i] <= bound_q) && (bound_q != '0);
		for (int i = 0; i < CAPACITY; i++) begin
			if (le[i] && (i == CAPACITY - 1 || !le[(i < CAPACITY - 1) ? i + 1 : i]))
				pop_c = pop_c | HW'(i + 1);
		end
	end

	// plan: number of items to deliver and what stays afterwards
	always_comb begin
		d_c = pop_q;
		if (op_q == trq_pkg::CMD_QUEUE) begin
			if (!stamp_ok || held_q < lim)
				d_c = '0;
			else if (7'(pop_q) > 7'(trq_pkg::BATCH))
				d_c = HW'(trq_pkg::BATCH);
		end else if (op_q == trq_pkg::CMD_FLUSH_COUNT) begin
			if (arg_q != '0 && arg_q < 64'(pop_q))
				d_c = HW'(arg_q);
		end else if (op_q > trq_pkg::CMD_FLUSH_ROUND) begin
			d_c = '0;
		end
		h1_c = held_q - d_c;
	end

	// insert position: cells strictly newer than the new stamp move up
	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			gt[i] = (HW'(i) < held_q) && (time_q[i] > ts_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_data.command;
			ts_q <= in_data.timestamp;
			pl_q <= in_data.payload;
			inst_q <= in_data.instance_req;
			arg_q <= in_data.flush_arg;
		end
		if (cmd.bound)
			bound_q <= bound_c;
		if (cmd.count)
			pop_q <= pop_c;
		if (cmd.emit_event) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				time_q[i] <= time_q[i+1];
				handle_q[i] <= handle_q[i+1];
				source_q[i] <= source_q[i+1];
			end
		end else if (cmd.insert) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					time_q[i] <= time_q[(i > 0) ? i - 1 : 0];
					handle_q[i] <= handle_q[(i > 0) ? i - 1 : 0];
					source_q[i] <= source_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || HW'(i) == held_q) begin
					time_q[i] <= ts_q;
					handle_q[i] <= pl_q;
					source_q[i] <= inst_q;
				end
			end
		end
		if (cmd.emit_event) begin
			out_q.kind <= trq_pkg::KIND_EVENT;
			out_q.out_timestamp <= time_q[0];
			out_q.out_payload <= handle_q[0];
			out_q.out_instance <= source_q[0];
			out_q.status <= trq_pkg::ST_OK;
			out_q.unordered_total <= late_q;
			out_q.held_count <= 6'(held_after_q);
			out_q.last_of_run <= 1'b0;
		end else if (cmd.emit_done) begin
			out_q.kind <= trq_pkg::KIND_DONE;
			out_q.out_timestamp <= '0;
			out_q.out_payload <= '0;
			out_q.out_instance <= '0;
			out_q.status <= status_q;
			out_q.unordered_total <= late_q;
			out_q.held_count <= 6'(held_after_q);
			out_q.last_of_run <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			newest_q <= '0;
			last_flushed_q <= '0;
			round_bound_q <= '0;
			late_q <= '0;
			cap_q <= trq_pkg::CAP_LIMIT_RST;
			rem_q <= '0;
			ins_q <= 1'b0;
			status_q <= trq_pkg::ST_OK;
			held_after_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				cap_q <= cfg_wr_data;
			if (cmd.load && in_data.command == trq_pkg::CMD_QUEUE
					&& in_data.timestamp != '0 && in_data.timestamp != '1
					&& in_data.timestamp < last_flushed_q && late_q != '1)
				late_q <= late_q + 32'd1;
			if (cmd.plan) begin
				rem_q <= d_c;
				ins_q <= 1'b0;
				status_q <= trq_pkg::ST_OK;
				held_after_q <= h1_c;
				if (op_q == trq_pkg::CMD_QUEUE) begin
					if (!stamp_ok) begin
						status_q <= trq_pkg::ST_INVALID;
					end else if (h1_c < lim) begin
						ins_q <= 1'b1;
						held_after_q <= h1_c + HW'(1);
					end else begin
						status_q <= trq_pkg::ST_NO_ROOM;
					end
				end
				if (op_q == trq_pkg::CMD_FLUSH_ROUND && held_q != '0)
					round_bound_q <= newest_q;
			end
			if (cmd.emit_event) begin
				rem_q <= rem_q - HW'(1);
				held_q <= held_q - HW'(1);
				last_flushed_q <= time_q[0];
			end
			if (cmd.insert) begin
				held_q <= held_q + HW'(1);
				if (ts_q > newest_q)
					newest_q <= ts_q;
			end
			if (cmd.emit_event || cmd.emit_done)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign stat.rem_zero = (rem_q == '0);
	assign stat.do_insert = ins_q;
	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

>>> src/timestamp_reorder_queue.sv
// Timestamp reorder queue: top level joining controller and datapath.
// Depends on trq_pkg, trq_ctrl and trq_dpath.
//
// Input channel in_valid/in_stall/in_data carries one command item. The
// block accepts one command at a time; in_stall stays high until the
// command's last result item has been loaded into the output register.
// Output channel out_valid/out_stall/out_data gives the delivered events,
// oldest first, then one done item with last_of_run set.
// Sequence: load the command, work out the bound, count and plan the drain,
// then deliver one event per cycle while the output register is free, leave
// the drain, make a sorted insert into the cell chain for a queue command
// with room, and load the done item.
// When the receiver stalls the output register holds its item and the
// drain pauses; nothing is dropped.
// capacity_limit is written through cfg_wr_en/cfg_wr_data; the user must write it only while idle (not enforced).
// Reset (arst_n low) empties the queue, clears the counters and sets
// capacity_limit to 32; the store needs no clearing pass.
module timestamp_reorder_queue #(
	parameter int CAPACITY = trq_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input trq_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output trq_pkg::out_item_t out_data,
	input logic cfg_wr_en,
	input logic [5:0] cfg_wr_data
);

	trq_pkg::dp_cmd_t cmd;
	trq_pkg::dp_stat_t stat;

	trq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.stat(stat)
	);

	trq_dpath #(.CAPACITY(CAPACITY)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data(out_data),
		.cmd(cmd),
		.stat(stat)
	);

endmodule

>>> verif/tb_top.sv
// Testbench for the timestamp reorder queue: directed and random commands,
// checked against a behavioural copy of the sorted store. Depends on trq_pkg.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] CMD_NONE = 3'd6;
	localparam logic [2:0] CMD_SPARE = 3'd7;
	localparam logic [63:0] ALL_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	trq_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	trq_pkg::out_item_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = '0;

	timestamp_reorder_queue uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	// shadow of the block's state
	logic [63:0] q_time [trq_pkg::CAPACITY_DEF];
	logic [31:0] q_handle [trq_pkg::CAPACITY_DEF];
	logic [15:0] q_source [trq_pkg::CAPACITY_DEF];
	int unsigned q_held = 0;
	logic [63:0] q_newest = '0;
	logic [63:0] q_last_flushed = '0;
	logic [63:0] q_round = '0;
	logic [31:0] q_late = '0;
	logic [5:0] q_limit = trq_pkg::CAP_LIMIT_RST;

	trq_pkg::out_item_t pending_results[$];
	int errors = 0;
	int stall_mode = 0;

	function automatic void drain_upto(input logic [63:0] bound, input logic [63:0] count,
			ref trq_pkg::out_item_t res[$]);
		int unsigned d;
		trq_pkg::out_item_t r;
		d = 0;
		if (bound == 0) return;
		while (d < q_held && q_time[d] <= bound) begin
			r = '0;
			r.kind = trq_pkg::KIND_EVENT;
			r.out_timestamp = q_time[d];
			r.out_payload = q_handle[d];
			r.out_instance = q_source[d];
			res.push_back(r);
			q_last_flushed = q_time[d];
			d++;
			if (count != 0 && 64'(d) == count) break;
		end
		for (int i = d; i < q_held; i++) begin
			q_time[i-d] = q_time[i];
			q_handle[i-d] = q_handle[i];
			q_source[i-d] = q_source[i];
		end
		q_held -= d;
	endfunction

	function automatic void store_sorted(input trq_pkg::in_item_t it);
		int unsigned pos;
		pos = 0;
		while (pos < q_held && q_time[pos] <= it.timestamp) pos++;
		for (int i = q_held; i > pos; i--) begin
			q_time[i] = q_time[i-1];
			q_handle[i] = q_handle[i-1];
			q_source[i] = q_source[i-1];
		end
		q_time[pos] = it.timestamp;
		q_handle[pos] = it.payload;
		q_source[pos] = it.instance_req;
		q_held++;
		if (it.timestamp > q_newest) q_newest = it.timestamp;
	endfunction

	function automatic void predict_command(input trq_pkg::in_item_t it);
		trq_pkg::out_item_t res[$];
		trq_pkg::out_item_t r;
		int unsigned lim;
		logic [1:0] st;
		logic [63:0] span;
		st = trq_pkg::ST_OK;
		lim = (q_limit > trq_pkg::CAPACITY_DEF) ? trq_pkg::CAPACITY_DEF : q_limit;
		case (it.command)
			trq_pkg::CMD_QUEUE: begin
				if (it.timestamp == 0 || it.timestamp == ALL_ONES) st = trq_pkg::ST_INVALID;
				else begin
					if (it.timestamp < q_last_flushed && q_late != '1) q_late++;
					if (q_held >= lim) drain_upto(ALL_ONES, 64'(trq_pkg::BATCH), res);
					if (q_held < lim) store_sorted(it);
					else st = trq_pkg::ST_NO_ROOM;
				end
			end
			trq_pkg::CMD_FLUSH_ALL: if (q_held > 0) drain_upto(ALL_ONES, 0, res);
			trq_pkg::CMD_FLUSH_HALF: if (q_held > 0) begin
				span = (q_newest >= q_time[0]) ? q_newest - q_time[0] : 0;
				drain_upto(q_time[0] + span / 2, 0, res);
			end
			trq_pkg::CMD_FLUSH_COUNT: if (q_held > 0) drain_upto(ALL_ONES, it.flush_arg, res);
			trq_pkg::CMD_FLUSH_TIME: if (q_held > 0) drain_upto(it.flush_arg, 0, res);
			trq_pkg::CMD_FLUSH_ROUND: if (q_held > 0) begin
				drain_upto(q_round, 0, res);
				q_round = q_newest;
			end
			default: ;
		endcase
		r = '0;
		r.kind = trq_pkg::KIND_DONE;
		r.status = st;
		res.push_back(r);
		foreach (res[j]) begin
			res[j].unordered_total = q_late;
			res[j].held_count = 6'(q_held);
			res[j].last_of_run = (j == res.size() - 1);
			pending_results.push_back(res[j]);
		end
	endfunction

	// one item per handshake; random gaps before some items
	int burst_left = 0;
	task automatic send_item(input trq_pkg::in_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		predict_command(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_limit(input logic [5:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		q_limit = v;
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	always @(posedge clk) begin
		trq_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result item %h", $time, out_data);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_data !== e) begin
					$display("%0t mismatch: expected %h actual %h", $time, e, out_data);
					errors++;
				end
			end
		end
	end

	function automatic trq_pkg::in_item_t make_item(input logic [2:0] c,
			input logic [63:0] ts, input logic [63:0] arg);
		trq_pkg::in_item_t it;
		it.command = c;
		it.timestamp = ts;
		it.payload = $urandom;
		it.instance_req = 16'($urandom);
		it.flush_arg = arg;
		return it;
	endfunction

	function automatic logic [63:0] rand64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	task automatic test_directed();
		send_item(make_item(trq_pkg::CMD_FLUSH_ALL, 0, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, 0, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, ALL_ONES, ALL_ONES));
		send_item(make_item(trq_pkg::CMD_QUEUE, 64'd1, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, ALL_ONES - 1, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, 64'd100, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, 64'd100, 0));
		send_item(make_item(trq_pkg::CMD_FLUSH_HALF, 0, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, 64'd50, 0));
		send_item(make_item(trq_pkg::CMD_FLUSH_ROUND, 0, 0));
		send_item(make_item(trq_pkg::CMD_FLUSH_ROUND, 0, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, 64'd7, 0));
		send_item(make_item(trq_pkg::CMD_QUEUE, 64'd9, 0));
		send_item(make_item(trq_pkg::CMD_FLUSH_TIME, 0, 64'd0));
		send_item(make_item(trq_pkg::CMD_FLUSH_TIME, 0, 64'd8));
		send_item(make_item(trq_pkg::CMD_FLUSH_COUNT, 0, 64'h1_0000_0001));
		send_item(make_item(trq_pkg::CMD_QUEUE, 64'd3, 0));
		send_item(make_item(trq_pkg::CMD_FLUSH_COUNT, 0, 64'd0));
		send_item(make_item(CMD_NONE, 0, 0));
		send_item(make_item(CMD_SPARE, ALL_ONES, ALL_ONES));
		send_item(make_item(trq_pkg::CMD_FLUSH_ALL, 0, 0));
	endtask

	task automatic test_full_store(input logic [5:0] lim, input int n);
		set_limit(lim);
		for (int i = 0; i < n; i++)
			send_item(make_item(trq_pkg::CMD_QUEUE, 64'($urandom_range(1, 200)), 0));
		send_item(make_item(trq_pkg::CMD_FLUSH_ALL, 0, 0));
	endtask

	task automatic test_random(input int n);
		trq_pkg::in_item_t it;
		logic [63:0] base;
		base = 64'd1000;
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 30) stall_mode = $urandom_range(0, 2);
			if (i == n / 2) wait_idle();
			case ($urandom_range(0, 19))
				0: it = make_item(trq_pkg::CMD_QUEUE, rand64(), 0);
				1: it = make_item(trq_pkg::CMD_QUEUE,
					($urandom_range(0, 1)) ? 0 : ALL_ONES, 0);
				2: it = make_item(trq_pkg::CMD_FLUSH_ALL, rand64(), rand64());
				3: it = make_item(trq_pkg::CMD_FLUSH_HALF, rand64(), rand64());
				4: it = make_item(trq_pkg::CMD_FLUSH_COUNT, rand64(),
					($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 5)));
				5: it = make_item(trq_pkg::CMD_FLUSH_TIME, rand64(),
					($urandom_range(0, 3) == 0) ? rand64() : base + $urandom_range(0, 300));
				6: it = make_item(trq_pkg::CMD_FLUSH_ROUND, rand64(), rand64());
				7: it = make_item(3'($urandom_range(6, 7)), rand64(), rand64());
				default: begin
					// mostly ascending stamps with some late ones
					base = base + $urandom_range(0, 20);
					it = make_item(trq_pkg::CMD_QUEUE, base - $urandom_range(0, 40), rand64());
				end
			endcase
			send_item(it);
		end
		send_item(make_item(trq_pkg::CMD_FLUSH_ALL, 0, 0));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_mode = 1;
		test_full_store(6'd32, 40);
		test_full_store(6'd0, 3);
		test_full_store(6'd63, 36);
		test_full_store(6'd1, 4);
		test_full_store(6'd5, 12);
		set_limit(6'd20);
		test_random(150);
		set_limit(6'd32);
		stall_mode = 2;
		test_random(100);
		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
